// ===== rtl/lcrc_pkg.sv =====
// Shared constants, types and codes for the record-chain classifier.
package lcrc_pkg;

    localparam int MAX_PAYLOAD = 2048;
    localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int POS_W       = $clog2(MAX_PAYLOAD + 65536);

    localparam logic [7:0] BYTE_REC   = 8'hF7;
    localparam logic [7:0] BYTE_ALT   = 8'hFF;
    localparam logic [7:0] BYTE_SOLO  = 8'h01;

    localparam logic [1:0] CFG_MIN_LEN   = 2'd0;
    localparam logic [1:0] CFG_MAX_LEN   = 2'd1;
    localparam logic [1:0] CFG_DETECT_AT = 2'd2;

    localparam logic [15:0] RST_MIN_LEN   = 16'd2;
    localparam logic [15:0] RST_MAX_LEN   = 16'd1500;
    localparam logic [15:0] RST_DETECT_AT = 16'd2;

    localparam logic [1:0] VERDICT_UNDECIDED = 2'd0;
    localparam logic [1:0] VERDICT_DETECTED  = 2'd1;
    localparam logic [1:0] VERDICT_EXCLUDED  = 2'd2;
    localparam logic [1:0] VERDICT_OVERFLOW  = 2'd3;

    typedef struct packed {
        logic [15:0] min_len;
        logic [15:0] max_len;
        logic [15:0] detect_after;
    } t_cfg;

endpackage

// ===== rtl/lcrc_store.sv =====
// Payload byte store with one write port and one registered read port.
module lcrc_store (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [lcrc_pkg::ADDR_W-1:0] i_waddr,
    input  logic [7:0]                  i_wdata,
    input  logic [lcrc_pkg::ADDR_W-1:0] i_raddr,
    output logic [7:0]                  o_rdata
);

    logic [7:0] r_mem [lcrc_pkg::MAX_PAYLOAD];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/lcrc_walker.sv =====
// Byte loader and record-walk sequencer that produces the verdict.
module lcrc_walker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_last_byte,
    input  logic [15:0]                 i_packet_number,
    input  lcrc_pkg::t_cfg              i_cfg,
    input  logic [7:0]                  i_rdata,
    output logic                        o_we,
    output logic [lcrc_pkg::ADDR_W-1:0] o_waddr,
    output logic [lcrc_pkg::ADDR_W-1:0] o_raddr,
    output logic                        o_busy,
    output logic                        o_done,
    output logic [1:0]                  o_verdict
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE,
        ST_CHECK,
        ST_HEAD,
        ST_LENLO,
        ST_LENHI
    } t_state;

    t_state                       r_state;
    logic [lcrc_pkg::CNT_W-1:0]   r_count;
    logic                         r_ovf;
    logic [lcrc_pkg::CNT_W-1:0]   r_len;
    logic [7:0]                   r_b0;
    logic [lcrc_pkg::POS_W-1:0]   r_pos;
    logic [15:0]                  r_pkt;
    logic [7:0]                   r_rlen_lo;

    logic                         w_accept;
    logic                         w_room;
    logic [lcrc_pkg::POS_W-1:0]   w_len_ext;
    logic [lcrc_pkg::POS_W-1:0]   w_pos_p2;
    logic [lcrc_pkg::POS_W-1:0]   w_pos_p3;
    logic [15:0]                  w_rlen;
    logic                         w_rlen_bad;
    logic [1:0]                   w_end_verdict;

    assign w_accept  = i_start && (r_state == ST_IDLE);
    assign w_room    = (r_count < lcrc_pkg::CNT_W'(lcrc_pkg::MAX_PAYLOAD));
    assign w_len_ext = lcrc_pkg::POS_W'(r_len);
    assign w_pos_p2  = r_pos + lcrc_pkg::POS_W'(2);
    assign w_pos_p3  = r_pos + lcrc_pkg::POS_W'(3);
    assign w_rlen    = {i_rdata, r_rlen_lo};
    assign w_rlen_bad = (w_rlen == 16'd0) || (w_rlen <= i_cfg.min_len)
                        || (w_rlen > i_cfg.max_len);
    assign w_end_verdict = (r_pos != w_len_ext) ? lcrc_pkg::VERDICT_EXCLUDED :
                           (r_pkt > i_cfg.detect_after) ? lcrc_pkg::VERDICT_DETECTED :
                           lcrc_pkg::VERDICT_UNDECIDED;

    assign o_we    = w_accept && w_room;
    assign o_waddr = r_count[lcrc_pkg::ADDR_W-1:0];
    assign o_busy  = (r_state != ST_IDLE);

    always_comb begin
        case (r_state)
            ST_HEAD:  o_raddr = w_pos_p2[lcrc_pkg::ADDR_W-1:0];
            ST_LENLO: o_raddr = w_pos_p3[lcrc_pkg::ADDR_W-1:0];
            default:  o_raddr = r_pos[lcrc_pkg::ADDR_W-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            o_done    <= 1'b0;
            o_verdict <= lcrc_pkg::VERDICT_UNDECIDED;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (w_room) begin
                            if (!i_last_byte) begin
                                r_count <= r_count + lcrc_pkg::CNT_W'(1);
                            end
                            if (r_count == lcrc_pkg::CNT_W'(0)) begin
                                r_b0  <= i_data_byte;
                                r_pos <= '0;
                            end
                            if (r_count == lcrc_pkg::CNT_W'(2)) begin
                                r_pos[7:0] <= i_data_byte;
                            end
                            if (r_count == lcrc_pkg::CNT_W'(3)) begin
                                r_pos[15:8] <= i_data_byte;
                            end
                        end else if (!i_last_byte) begin
                            r_ovf <= 1'b1;
                        end
                        if (i_last_byte) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            r_pkt   <= i_packet_number;
                            r_len   <= r_count + lcrc_pkg::CNT_W'(1);
                            if (!w_room || r_ovf) begin
                                o_done    <= 1'b1;
                                o_verdict <= lcrc_pkg::VERDICT_OVERFLOW;
                            end else begin
                                r_state <= ST_PRE;
                            end
                        end
                    end
                end
                ST_PRE: begin
                    if (r_pkt == 16'd1 && r_len == lcrc_pkg::CNT_W'(1)
                            && r_b0 == lcrc_pkg::BYTE_SOLO) begin
                        o_done    <= 1'b1;
                        o_verdict <= lcrc_pkg::VERDICT_UNDECIDED;
                        r_state   <= ST_IDLE;
                    end else if (r_len < lcrc_pkg::CNT_W'(4)
                            || (r_b0 != lcrc_pkg::BYTE_REC && r_b0 != lcrc_pkg::BYTE_ALT)) begin
                        o_done    <= 1'b1;
                        o_verdict <= lcrc_pkg::VERDICT_EXCLUDED;
                        r_state   <= ST_IDLE;
                    end else begin
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (r_pos <= w_len_ext - lcrc_pkg::POS_W'(4)) begin
                        r_state <= ST_HEAD;
                    end else begin
                        o_done    <= 1'b1;
                        o_verdict <= w_end_verdict;
                        r_state   <= ST_IDLE;
                    end
                end
                ST_HEAD: begin
                    if (i_rdata != lcrc_pkg::BYTE_REC) begin
                        o_done    <= 1'b1;
                        o_verdict <= w_end_verdict;
                        r_state   <= ST_IDLE;
                    end else begin
                        r_state <= ST_LENLO;
                    end
                end
                ST_LENLO: begin
                    r_rlen_lo <= i_rdata;
                    r_state   <= ST_LENHI;
                end
                ST_LENHI: begin
                    if (w_rlen_bad) begin
                        o_done    <= 1'b1;
                        o_verdict <= w_end_verdict;
                        r_state   <= ST_IDLE;
                    end else begin
                        r_pos   <= r_pos + lcrc_pkg::POS_W'(w_rlen);
                        r_state <= ST_CHECK;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/length_chained_record_classifier.sv =====
// Top level: configuration registers, payload store and record-walk sequencer.
// Bytes load one per cycle while o_busy is low; a non-final byte gives no result.
// After the final byte o_busy stays high through the header checks and, if they pass,
// through the walk over the record chain; o_done pulses as o_busy falls.
// An overflowed payload keeps o_busy low and reports in the cycle after its final byte.
// Synchronous reset clears control state and loads register defaults; the store is not cleared.
module length_chained_record_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [15:0] i_packet_number,
    output logic        o_done,
    output logic [1:0]  o_verdict,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    lcrc_pkg::t_cfg              r_cfg;
    logic                        w_we;
    logic [lcrc_pkg::ADDR_W-1:0] w_waddr;
    logic [lcrc_pkg::ADDR_W-1:0] w_raddr;
    logic [7:0]                  w_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_len      <= lcrc_pkg::RST_MIN_LEN;
            r_cfg.max_len      <= lcrc_pkg::RST_MAX_LEN;
            r_cfg.detect_after <= lcrc_pkg::RST_DETECT_AT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lcrc_pkg::CFG_MIN_LEN:   r_cfg.min_len      <= i_cfg_data;
                lcrc_pkg::CFG_MAX_LEN:   r_cfg.max_len      <= i_cfg_data;
                lcrc_pkg::CFG_DETECT_AT: r_cfg.detect_after <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    lcrc_store u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_data_byte),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    lcrc_walker u_walker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .i_packet_number (i_packet_number),
        .i_cfg           (r_cfg),
        .i_rdata         (w_rdata),
        .o_we            (w_we),
        .o_waddr         (w_waddr),
        .o_raddr         (w_raddr),
        .o_busy          (o_busy),
        .o_done          (o_done),
        .o_verdict       (o_verdict)
    );

endmodule
